// ----- sv/finite_difference_stencil_defines.svh -----
// ----------------------------------------------------------------------------
// Finite-difference stencil assertion macros
// Shared concurrent assertion forms for the stencil block.
// ----------------------------------------------------------------------------
`ifndef FINITE_DIFFERENCE_STENCIL_DEFINES_SVH
`define FINITE_DIFFERENCE_STENCIL_DEFINES_SVH

// same-cycle implication
`define FDS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FDS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/fds_pkg.sv -----
// ----------------------------------------------------------------------------
// Finite-difference stencil package
// Sizes, register and operator codes, and pipeline stage types.
// ----------------------------------------------------------------------------
`default_nettype none

package fds_pkg;

   localparam int MAX_ROWS    = 1024;
   localparam int SAMPLE_BITS = 32;

   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int RCNT_W     = ROW_W + 1;
   localparam int ROWS_CFG_W = 11;
   localparam int COL_W      = 16;
   localparam int OUT_ROW_W  = 10;
   localparam int MODE_W     = 3;
   localparam int RECIP_W    = 32;
   localparam int FRAC_W     = 16;
   localparam int CSR_W      = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int MIN_DIM    = 3;

   localparam int DIFF_W = SAMPLE_BITS + 3;
   localparam int MAG_W  = SAMPLE_BITS + 2;
   localparam int PP_W   = MAG_W + RECIP_W - FRAC_W;
   localparam int PROD_W = PP_W + 1;
   localparam int CMP_W  = (ROWS_CFG_W > RCNT_W) ? ROWS_CFG_W : RCNT_W;

   localparam logic [PROD_W-1:0] SAT_NEG_MAG = PROD_W'(1) << (SAMPLE_BITS - 1);
   localparam logic [PROD_W-1:0] SAT_POS_MAG = SAT_NEG_MAG - PROD_W'(1);
   localparam logic [PROD_W-1:0] ROUND_HALF  = PROD_W'(1) << (FRAC_W - 1);
   localparam logic [RECIP_W-1:0] RECIP_ONE  = RECIP_W'(1) << FRAC_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_X_FWD    = 3'd0,
      MODE_X_BWD    = 3'd1,
      MODE_Y_FWD    = 3'd2,
      MODE_Y_BWD    = 3'd3,
      MODE_X_SECOND = 3'd4,
      MODE_Y_SECOND = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      CSR_OPERATOR_MODE   = 3'd0,
      CSR_GRID_ROWS       = 3'd1,
      CSR_GRID_COLS       = 3'd2,
      CSR_RECIP_STEP_X    = 3'd3,
      CSR_RECIP_STEP_Y    = 3'd4,
      CSR_RECIP_STEP_X_SQ = 3'd5,
      CSR_RECIP_STEP_Y_SQ = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] older;
      logic [SAMPLE_BITS-1:0] newer;
   } entry_type;

   typedef struct packed {
      logic                   zero;
      logic [MODE_W-1:0]      mode;
      logic [SAMPLE_BITS-1:0] sample;
      logic [SAMPLE_BITS-1:0] mid;
      logic [SAMPLE_BITS-1:0] left;
      logic [SAMPLE_BITS-1:0] dn;
      logic [SAMPLE_BITS-1:0] up;
      logic [RECIP_W-1:0]     recip;
      logic [OUT_ROW_W-1:0]   row;
      logic [COL_W-1:0]       col;
      logic                   done;
   } s1_type;

   typedef struct packed {
      logic [DIFF_W-1:0]    d;
      logic [RECIP_W-1:0]   recip;
      logic [OUT_ROW_W-1:0] row;
      logic [COL_W-1:0]     col;
      logic                 done;
   } s2_type;

   typedef struct packed {
      logic                 neg;
      logic [MAG_W-1:0]     mag;
      logic [RECIP_W-1:0]   recip;
      logic [OUT_ROW_W-1:0] row;
      logic [COL_W-1:0]     col;
      logic                 done;
   } s3_type;

   typedef struct packed {
      logic                 neg;
      logic [PP_W-1:0]      pp_hi;
      logic [PP_W-1:0]      pp_lo;
      logic [OUT_ROW_W-1:0] row;
      logic [COL_W-1:0]     col;
      logic                 done;
   } s4_type;

   typedef struct packed {
      logic                 neg;
      logic [PROD_W-1:0]    prod;
      logic [OUT_ROW_W-1:0] row;
      logic [COL_W-1:0]     col;
      logic                 done;
   } s5_type;

   function automatic logic [DIFF_W-1:0] sext_diff(input logic [SAMPLE_BITS-1:0] v);
      return {{(DIFF_W - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
   endfunction

endpackage

`default_nettype wire

// ----- sv/finite_difference_stencil.sv -----
// ----------------------------------------------------------------------------
// Finite-difference stencil
// Streams a column-major grid through two column line buffers and emits
// one saturated, scaled first or second difference per point of the
// previous column.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  req      | in        | req_valid / req_ready | req_sample
//  rsp      | out       | rsp_valid / rsp_ready | rsp_deriv_value, rsp_out_row,
//           |           |                       | rsp_out_col, rsp_grid_done
//  csr      | in/out    | psel/penable/pready   | paddr, pwdata, prdata
//
//  One item per cycle while req_ready is high; a result leaves through
//  five arithmetic stages and the output register, fed by one memory read.
//  Items of the first column of a grid give no result.
//  A write to grid_rows or grid_cols holds req_ready low for one cycle while
//  the two line-buffer read ports refetch. Reset holds it low for one cycle.
//  A stalled result holds the pipeline stage by stage; bubbles still fill.
// ----------------------------------------------------------------------------
`default_nettype none
`include "finite_difference_stencil_defines.svh"

module finite_difference_stencil import fds_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_deriv_value,
   output logic [OUT_ROW_W-1:0]   rsp_out_row,
   output logic [COL_W-1:0]       rsp_out_col,
   output logic                   rsp_grid_done,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_W-1:0]       pwdata,
   output logic [CSR_W-1:0]       prdata,
   output logic                   pready
);

   logic [MODE_W-1:0]     op_mode_ff;
   logic [ROWS_CFG_W-1:0] grid_rows_ff;
   logic [COL_W-1:0]      grid_cols_ff;
   logic [RECIP_W-1:0]    recip_x_ff;
   logic [RECIP_W-1:0]    recip_y_ff;
   logic [RECIP_W-1:0]    recip_x_sq_ff;
   logic [RECIP_W-1:0]    recip_y_sq_ff;

   logic        csr_wr;
   csr_idx_type csr_idx;

   logic [ROW_W-1:0] row_pos_ff;
   logic [COL_W-1:0] col_pos_ff;
   logic             win_ok_ff;
   logic             win_ok_in;

   entry_type        col_mem [MAX_ROWS];
   entry_type        cur_entry_ff;
   entry_type        nxt_entry_ff;
   logic [SAMPLE_BITS-1:0] up_ff;

   logic [RCNT_W-1:0] rows_eff;
   logic [COL_W-1:0]  cols_eff;
   logic [CMP_W-1:0]  rows_cfg_x;
   logic              restart;
   logic [ROW_W-1:0]  cur_row;
   logic [COL_W-1:0]  cur_col;
   logic [RCNT_W-1:0] row_inc;
   logic [COL_W:0]    col_inc;
   logic              last_row;
   logic              last_col;
   logic [ROW_W-1:0]  nxt_row;
   logic [COL_W-1:0]  nxt_col;
   logic [ROW_W-1:0]  base_row;
   logic [RCNT_W-1:0] base_inc;
   logic [ROW_W-1:0]  rd_nxt_addr;
   logic              inner;
   logic              req_accept;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   logic   s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   logic   en1, en2, en3, en4, en5, en_out;

   logic [DIFF_W-1:0] dn_x, mid_x, up_x, left_x, smp_x, mid2_x, dneg;

   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_deriv_value_ff;
   logic [SAMPLE_BITS-1:0] rsp_deriv_value_in;
   logic [SAMPLE_BITS-1:0] prod_neg;
   logic [OUT_ROW_W-1:0]   rsp_out_row_ff;
   logic [COL_W-1:0]       rsp_out_col_ff;
   logic                   rsp_grid_done_ff;

   // configuration port
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = csr_idx_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff    <= MODE_X_FWD;
         grid_rows_ff  <= ROWS_CFG_W'(MIN_DIM);
         grid_cols_ff  <= COL_W'(MIN_DIM);
         recip_x_ff    <= RECIP_ONE;
         recip_y_ff    <= RECIP_ONE;
         recip_x_sq_ff <= RECIP_ONE;
         recip_y_sq_ff <= RECIP_ONE;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_OPERATOR_MODE:   op_mode_ff    <= pwdata[MODE_W-1:0];
            CSR_GRID_ROWS:       grid_rows_ff  <= pwdata[ROWS_CFG_W-1:0];
            CSR_GRID_COLS:       grid_cols_ff  <= pwdata[COL_W-1:0];
            CSR_RECIP_STEP_X:    recip_x_ff    <= pwdata[RECIP_W-1:0];
            CSR_RECIP_STEP_Y:    recip_y_ff    <= pwdata[RECIP_W-1:0];
            CSR_RECIP_STEP_X_SQ: recip_x_sq_ff <= pwdata[RECIP_W-1:0];
            CSR_RECIP_STEP_Y_SQ: recip_y_sq_ff <= pwdata[RECIP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_OPERATOR_MODE:   prdata = CSR_W'(op_mode_ff);
         CSR_GRID_ROWS:       prdata = CSR_W'(grid_rows_ff);
         CSR_GRID_COLS:       prdata = CSR_W'(grid_cols_ff);
         CSR_RECIP_STEP_X:    prdata = CSR_W'(recip_x_ff);
         CSR_RECIP_STEP_Y:    prdata = CSR_W'(recip_y_ff);
         CSR_RECIP_STEP_X_SQ: prdata = CSR_W'(recip_x_sq_ff);
         CSR_RECIP_STEP_Y_SQ: prdata = CSR_W'(recip_y_sq_ff);
         default:             prdata = '0;
      endcase
   end

   // grid position
   always_comb begin
      rows_cfg_x = CMP_W'(grid_rows_ff);
      if (rows_cfg_x < CMP_W'(MIN_DIM)) begin
         rows_eff = RCNT_W'(MIN_DIM);
      end else if (rows_cfg_x > CMP_W'(MAX_ROWS)) begin
         rows_eff = RCNT_W'(MAX_ROWS);
      end else begin
         rows_eff = RCNT_W'(rows_cfg_x);
      end
      cols_eff = (grid_cols_ff < COL_W'(MIN_DIM)) ? COL_W'(MIN_DIM) : grid_cols_ff;

      restart  = ({1'b0, row_pos_ff} >= rows_eff) || (col_pos_ff >= cols_eff);
      cur_row  = restart ? '0 : row_pos_ff;
      cur_col  = restart ? '0 : col_pos_ff;
      row_inc  = {1'b0, cur_row} + RCNT_W'(1);
      col_inc  = {1'b0, cur_col} + (COL_W + 1)'(1);
      last_row = row_inc >= rows_eff;
      last_col = col_inc >= {1'b0, cols_eff};
      nxt_row  = last_row ? '0 : row_inc[ROW_W-1:0];
      nxt_col  = last_row ? (last_col ? '0 : col_inc[COL_W-1:0]) : cur_col;

      inner = (cur_row != '0) && !last_row && (cur_col >= COL_W'(2));

      // prefetch the entry of the next row to be taken and the one after it
      base_row    = req_accept ? nxt_row : cur_row;
      base_inc    = {1'b0, base_row} + RCNT_W'(1);
      rd_nxt_addr = (base_inc == rows_eff) ? '0 : base_inc[ROW_W-1:0];
   end

   assign req_ready  = win_ok_ff && en1;
   assign req_accept = req_valid && req_ready;
   assign win_ok_in  = !(csr_wr && (csr_idx == CSR_GRID_ROWS || csr_idx == CSR_GRID_COLS));

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff <= '0;
         col_pos_ff <= '0;
         win_ok_ff  <= 1'b0;
      end else begin
         win_ok_ff <= win_ok_in;
         if (req_accept) begin
            row_pos_ff <= nxt_row;
            col_pos_ff <= nxt_col;
         end
      end
   end

   // column line buffers: older and newer column share one entry per row
   always_ff @(posedge clock) begin
      if (req_accept) begin
         col_mem[cur_row] <= '{older: cur_entry_ff.newer, newer: req_sample};
         up_ff            <= cur_entry_ff.newer;
      end
      cur_entry_ff <= col_mem[base_row];
      nxt_entry_ff <= col_mem[rd_nxt_addr];
   end

   // pipeline advance
   assign en_out = !rsp_valid_ff || rsp_ready;
   assign en5    = !s5_vld_ff || en_out;
   assign en4    = !s4_vld_ff || en5;
   assign en3    = !s3_vld_ff || en4;
   assign en2    = !s2_vld_ff || en3;
   assign en1    = !s1_vld_ff || en2;

   // stage 1: operands
   always_comb begin
      s1_in.zero   = !inner;
      s1_in.mode   = op_mode_ff;
      s1_in.sample = req_sample;
      s1_in.mid    = cur_entry_ff.newer;
      s1_in.left   = cur_entry_ff.older;
      s1_in.dn     = nxt_entry_ff.newer;
      s1_in.up     = up_ff;
      s1_in.row    = OUT_ROW_W'(cur_row);
      s1_in.col    = cur_col - COL_W'(1);
      s1_in.done   = last_row && last_col;
      case (op_mode_ff)
         MODE_X_FWD, MODE_X_BWD: s1_in.recip = recip_x_ff;
         MODE_Y_FWD, MODE_Y_BWD: s1_in.recip = recip_y_ff;
         MODE_X_SECOND:          s1_in.recip = recip_x_sq_ff;
         MODE_Y_SECOND:          s1_in.recip = recip_y_sq_ff;
         default:                s1_in.recip = '0;
      endcase
   end

   // stage 2: difference
   always_comb begin
      dn_x   = sext_diff(s1_ff.dn);
      mid_x  = sext_diff(s1_ff.mid);
      up_x   = sext_diff(s1_ff.up);
      left_x = sext_diff(s1_ff.left);
      smp_x  = sext_diff(s1_ff.sample);
      mid2_x = {mid_x[DIFF_W-2:0], 1'b0};
      case (s1_ff.mode)
         MODE_X_FWD:    s2_in.d = dn_x - mid_x;
         MODE_X_BWD:    s2_in.d = mid_x - up_x;
         MODE_Y_FWD:    s2_in.d = smp_x - mid_x;
         MODE_Y_BWD:    s2_in.d = mid_x - left_x;
         MODE_X_SECOND: s2_in.d = dn_x - mid2_x + up_x;
         MODE_Y_SECOND: s2_in.d = smp_x - mid2_x + left_x;
         default:       s2_in.d = '0;
      endcase
      if (s1_ff.zero) begin
         s2_in.d = '0;
      end
      s2_in.recip = s1_ff.recip;
      s2_in.row   = s1_ff.row;
      s2_in.col   = s1_ff.col;
      s2_in.done  = s1_ff.done;
   end

   // stage 3: sign and magnitude
   always_comb begin
      dneg        = '0 - s2_ff.d;
      s3_in.neg   = s2_ff.d[DIFF_W-1];
      s3_in.mag   = s2_ff.d[DIFF_W-1] ? dneg[MAG_W-1:0] : s2_ff.d[MAG_W-1:0];
      s3_in.recip = s2_ff.recip;
      s3_in.row   = s2_ff.row;
      s3_in.col   = s2_ff.col;
      s3_in.done  = s2_ff.done;
   end

   // stage 4: partial products against the integer and fraction halves
   always_comb begin
      s4_in.neg   = s3_ff.neg;
      s4_in.pp_hi = PP_W'(s3_ff.mag) * PP_W'(s3_ff.recip[RECIP_W-1:FRAC_W]);
      s4_in.pp_lo = PP_W'(s3_ff.mag) * PP_W'(s3_ff.recip[FRAC_W-1:0]);
      s4_in.row   = s3_ff.row;
      s4_in.col   = s3_ff.col;
      s4_in.done  = s3_ff.done;
   end

   // stage 5: round to nearest, ties away from zero
   always_comb begin
      s5_in.neg  = s4_ff.neg;
      s5_in.prod = PROD_W'(s4_ff.pp_hi)
                 + ((PROD_W'(s4_ff.pp_lo) + ROUND_HALF) >> FRAC_W);
      s5_in.row  = s4_ff.row;
      s5_in.col  = s4_ff.col;
      s5_in.done = s4_ff.done;
   end

   // output: apply sign and saturate
   always_comb begin
      prod_neg = '0 - s5_ff.prod[SAMPLE_BITS-1:0];
      if (s5_ff.neg) begin
         rsp_deriv_value_in = (s5_ff.prod >= SAT_NEG_MAG) ?
                              SAT_NEG_MAG[SAMPLE_BITS-1:0] : prod_neg;
      end else begin
         rsp_deriv_value_in = (s5_ff.prod > SAT_POS_MAG) ?
                              SAT_POS_MAG[SAMPLE_BITS-1:0] :
                              s5_ff.prod[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         s5_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_vld_ff <= req_accept && (cur_col != '0);
         end
         if (en2) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (en3) begin
            s3_vld_ff <= s2_vld_ff;
         end
         if (en4) begin
            s4_vld_ff <= s3_vld_ff;
         end
         if (en5) begin
            s5_vld_ff <= s4_vld_ff;
         end
         if (en_out) begin
            rsp_valid_ff <= s5_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= s1_in;
      end
      if (en2) begin
         s2_ff <= s2_in;
      end
      if (en3) begin
         s3_ff <= s3_in;
      end
      if (en4) begin
         s4_ff <= s4_in;
      end
      if (en5) begin
         s5_ff <= s5_in;
      end
      if (en_out) begin
         rsp_deriv_value_ff <= rsp_deriv_value_in;
         rsp_out_row_ff     <= s5_ff.row;
         rsp_out_col_ff     <= s5_ff.col;
         rsp_grid_done_ff   <= s5_ff.done;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_deriv_value = rsp_deriv_value_ff;
   assign rsp_out_row     = rsp_out_row_ff;
   assign rsp_out_col     = rsp_out_col_ff;
   assign rsp_grid_done   = rsp_grid_done_ff;

   `FDS_ASSERT_NEXT(a_size_write_refetch, clock, reset, csr_wr && (csr_idx == CSR_GRID_ROWS || csr_idx == CSR_GRID_COLS), !req_ready, "item taken before line-buffer refetch")
   `FDS_ASSERT_IMPLY(a_border_zero, clock, reset, rsp_valid_ff && (rsp_out_row_ff == '0 || rsp_out_col_ff == '0), rsp_deriv_value_ff == '0, "border result not zero")
   `FDS_ASSERT_NEXT(a_first_col_silent, clock, reset, req_accept && (cur_col == '0), !s1_vld_ff, "first column produced a result")
   `FDS_ASSERT_NEXT(a_later_col_emits, clock, reset, req_accept && (cur_col != '0), s1_vld_ff, "item of a later column dropped")

endmodule

`default_nettype wire
